### sv/interior_pointer_range_lookup_defines.svh
// Assertion macros shared by the range lookup block.
`ifndef INTERIOR_POINTER_RANGE_LOOKUP_DEFINES_SVH
`define INTERIOR_POINTER_RANGE_LOOKUP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define IPRL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define IPRL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### sv/iprl_pkg.sv
package iprl_pkg;

    localparam int ADDR_W = 64;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    typedef struct packed {
        logic              have;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
    } t_cand;

endpackage

### sv/interior_pointer_range_lookup.sv
// Channel | Valid       | Stall       | Payload
// input   | i_in_valid  | o_in_stall  | i_command, i_object_base, i_object_size, i_address
// output  | o_out_valid | i_out_stall | o_found, o_containing_base, o_status
//
// Clear, insert and unused commands go straight to the output register; a query launches
// a candidate along the row of cells, one cell per cycle, then holds its result in S_DONE.
// One item is in flight at a time; new items are taken only in S_IDLE, not during a query.
// Reset is synchronous and active low and empties the table; it needs no clearing pass.
// A stalled result is held in the output register and stalls the input until it is taken.
module interior_pointer_range_lookup #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_command,
    input  logic [iprl_pkg::ADDR_W-1:0]  i_object_base,
    input  logic [iprl_pkg::ADDR_W-1:0]  i_object_size,
    input  logic [iprl_pkg::ADDR_W-1:0]  i_address,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_found,
    output logic [iprl_pkg::ADDR_W-1:0]  o_containing_base,
    output logic                         o_status
);
    import iprl_pkg::*;

    `include "interior_pointer_range_lookup_defines.svh"

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    logic [ADDR_W-1:0] r_addr;
    logic              r_launch;
    logic              r_res_found;
    logic [ADDR_W-1:0] r_res_base;
    logic              r_o_valid;
    logic              r_o_found;
    logic [ADDR_W-1:0] r_o_base;
    logic              r_o_status;

    logic              w_accept;
    logic              w_full;
    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_hi;
    logic              w_slot_free;
    logic              w_hit;
    logic              w_tok  [TABLE_ENTRIES+1];
    t_cand             w_cand [TABLE_ENTRIES+1];

    assign w_slot_free = !r_o_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE) || !w_slot_free;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_full      = r_count == CNT_W'(TABLE_ENTRIES);
    assign w_wr_en     = w_accept && (i_command == CMD_INSERT) && !w_full;
    assign w_wr_hi     = i_object_base + i_object_size;

    assign w_tok[0]       = r_launch;
    assign w_cand[0].have = 1'b0;
    assign w_cand[0].lo   = '0;
    assign w_cand[0].hi   = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        iprl_cell #(
            .CNT_W (CNT_W),
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_count (r_count),
            .i_wr_en (w_wr_en),
            .i_wr_lo (i_object_base),
            .i_wr_hi (w_wr_hi),
            .i_addr  (r_addr),
            .i_tok   (w_tok[g]),
            .i_cand  (w_cand[g]),
            .o_tok   (w_tok[g+1]),
            .o_cand  (w_cand[g+1])
        );
    end

    // The winning start never lies above the address, so only the end needs checking.
    assign w_hit = w_cand[TABLE_ENTRIES].have && (r_addr != '0)
                   && (r_addr < w_cand[TABLE_ENTRIES].hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_launch  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_launch <= 1'b0;
            if (r_o_valid && !i_out_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_command == CMD_QUERY) begin
                            r_addr   <= i_address;
                            r_launch <= 1'b1;
                            r_state  <= S_WALK;
                        end else begin
                            r_o_valid  <= 1'b1;
                            r_o_found  <= 1'b0;
                            r_o_base   <= '0;
                            r_o_status <= (i_command == CMD_INSERT) && w_full;
                            if (i_command == CMD_CLEAR) begin
                                r_count <= '0;
                            end else if (w_wr_en) begin
                                r_count <= r_count + CNT_W'(1);
                            end
                        end
                    end
                end
                S_WALK: begin
                    if (w_tok[TABLE_ENTRIES]) begin
                        r_res_found <= w_hit;
                        r_res_base  <= w_hit ? w_cand[TABLE_ENTRIES].lo : '0;
                        r_state     <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_slot_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_found  <= r_res_found;
                        r_o_base   <= r_res_base;
                        r_o_status <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid       = r_o_valid;
    assign o_found           = r_o_found;
    assign o_containing_base = r_o_base;
    assign o_status          = r_o_status;

    `IPRL_ASSERT_NEXT(a_full_insert_flagged, w_accept && (i_command == CMD_INSERT) && w_full, o_out_valid && o_status && $stable(r_count), "insert into a full table was not flagged")
    `IPRL_ASSERT_NOW(a_tail_only_in_walk, w_tok[TABLE_ENTRIES], r_state == S_WALK, "candidate left the row outside a query walk")
    `IPRL_ASSERT_NEXT(a_count_held_in_walk, r_state == S_WALK, $stable(r_count), "fill count changed during a query walk")
    `IPRL_ASSERT_NOW(a_found_not_flagged, o_out_valid && o_found, !o_status, "query result carries a drop flag")

endmodule

### sv/iprl_cell.sv
module iprl_cell #(
    parameter int CNT_W = 9,
    parameter int INDEX = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [CNT_W-1:0]             i_count,
    input  logic                         i_wr_en,
    input  logic [iprl_pkg::ADDR_W-1:0]  i_wr_lo,
    input  logic [iprl_pkg::ADDR_W-1:0]  i_wr_hi,
    input  logic [iprl_pkg::ADDR_W-1:0]  i_addr,
    input  logic                         i_tok,
    input  iprl_pkg::t_cand              i_cand,
    output logic                         o_tok,
    output iprl_pkg::t_cand              o_cand
);
    import iprl_pkg::*;

    logic [ADDR_W-1:0] r_lo;
    logic [ADDR_W-1:0] r_hi;
    logic              r_tok;
    t_cand             r_cand;
    logic              w_live;
    logic              w_take;

    // An entry at or above the fill count is stale and never competes.
    assign w_live = CNT_W'(INDEX) < i_count;
    assign w_take = w_live && (r_lo <= i_addr) && (!i_cand.have || (r_lo >= i_cand.lo));

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_count == CNT_W'(INDEX))) begin
            r_lo <= i_wr_lo;
            r_hi <= i_wr_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cand.have <= 1'b1;
            r_cand.lo   <= r_lo;
            r_cand.hi   <= r_hi;
        end else begin
            r_cand <= i_cand;
        end
    end

    assign o_tok  = r_tok;
    assign o_cand = r_cand;

endmodule
